[src/pic_pkg.sv]
// Shared types, constants and parameter defaults of the platform interrupt controller.
`default_nettype none

package pic_pkg;

    // Parameter defaults.
    localparam int NUM_SOURCES_DEF   = 32;
    localparam int NUM_CONTEXTS_DEF  = 2;
    localparam int PRIORITY_BITS_DEF = 3;
    localparam int ID_W_DEF          = 5;
    localparam int DATA_W            = 32;

    // Commands carried by an input beat.
    typedef enum logic [1:0] {
        CMD_READ   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_LEVELS = 2'd2
    } t_cmd;

    // Register map.
    localparam logic [25:0] ENABLE_BASE   = 26'h000_2000;
    localparam logic [25:0] CONTEXT_BASE  = 26'h020_0000;
    localparam logic [11:0] THRESH_OFFSET = 12'h000;
    localparam logic [11:0] CLAIM_OFFSET  = 12'h004;

    // Control of the shared priority compare unit.
    typedef struct packed {
        logic clear;
        logic step;
        logic cand;
    } t_scan_ctl;

endpackage

`default_nettype wire

[src/pic_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module pic_ram #(
    parameter int WIDTH = pic_pkg::DATA_W,
    parameter int DEPTH = pic_pkg::NUM_SOURCES_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[src/pic_scan.sv]
// Shared priority compare unit that keeps the best claimable source seen during a scan.
`default_nettype none

module pic_scan #(
    parameter int PRIORITY_BITS = pic_pkg::PRIORITY_BITS_DEF,
    parameter int ID_W          = pic_pkg::ID_W_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire pic_pkg::t_scan_ctl       i_ctl,
    input  wire logic [PRIORITY_BITS-1:0] i_prio,
    input  wire logic [PRIORITY_BITS-1:0] i_thr,
    input  wire logic [ID_W-1:0]          i_id,
    output logic      [ID_W-1:0]          o_best_id,
    output logic                          o_found
);

    logic                     r_found;
    logic [ID_W-1:0]          r_best_id;
    logic [PRIORITY_BITS-1:0] r_best_prio;
    logic                     take;

    // Strictly greater keeps the lowest id on a tie, as ids arrive in rising order.
    assign take = i_ctl.step && i_ctl.cand && (i_prio > i_thr) &&
                  (!r_found || (i_prio > r_best_prio));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_best_id   <= i_id;
            r_best_prio <= i_prio;
        end
    end

    assign o_best_id = r_found ? r_best_id : '0;
    assign o_found   = r_found;

endmodule

`default_nettype wire

[src/platform_interrupt_controller_top.sv]
// Top level of the platform interrupt controller: bus decode, sequencer and state.
// Each accepted beat is decoded and executed, then one scan of the sources is run per
// context, for at most two contexts, plus one more scan for a claim read. Scans are
// paced by the priority RAM read port, which serves one source per cycle; a new beat is
// taken only once the previous one has finished.
// Reset is synchronous; after it a clearing pass zeroes the RAMs while the input is stalled.
`default_nettype none

module platform_interrupt_controller_top #(
    parameter int NUM_SOURCES   = pic_pkg::NUM_SOURCES_DEF,
    parameter int NUM_CONTEXTS  = pic_pkg::NUM_CONTEXTS_DEF,
    parameter int PRIORITY_BITS = pic_pkg::PRIORITY_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_cmd,
    input  wire logic [25:0] i_addr,
    input  wire logic [31:0] i_wdata,
    input  wire logic [31:0] i_irq_levels,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_rdata,
    output logic [1:0]       o_eip
);

    // Enable words per context, and the sources that can ever become pending. Only the
    // first 32 sources have level lines, so pending and in-service bits, and every scan,
    // are limited to them.
    localparam int NUM_WORDS = (NUM_SOURCES + 31) / 32;
    localparam int NSCAN     = (NUM_SOURCES < 32) ? NUM_SOURCES : 32;
    localparam int IDW       = $clog2(NSCAN);
    localparam int PAW       = $clog2(NUM_SOURCES);
    localparam int CW        = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
    localparam int ENW       = NUM_CONTEXTS * NUM_WORDS;
    localparam int EAW       = (ENW > 1) ? $clog2(ENW) : 1;
    localparam int CLR_DEPTH = (NUM_SOURCES > ENW) ? NUM_SOURCES : ENW;
    localparam int CLRW      = $clog2(CLR_DEPTH);

    // Valid source bits of the last enable word, and of the pending vector (source zero
    // never exists).
    localparam logic [31:0] LAST_MASK = ((NUM_SOURCES % 32) == 0) ? 32'hFFFF_FFFF :
                                        32'((64'd1 << (NUM_SOURCES % 32)) - 64'd1);
    localparam logic [NSCAN-1:0] LV_MASK = {{(NSCAN-1){1'b1}}, 1'b0};

    typedef enum logic [7:0] {
        S_CLEAR   = 8'b0000_0001,
        S_IDLE    = 8'b0000_0010,
        S_READ    = 8'b0000_0100,
        S_EXEC    = 8'b0000_1000,
        S_SCAN_RD = 8'b0001_0000,
        S_SCAN    = 8'b0010_0000,
        S_POST    = 8'b0100_0000,
        S_FINISH  = 8'b1000_0000
    } t_state;

    // What the running scan is for.
    typedef enum logic [1:0] {
        JOB_CLAIM = 2'd0,
        JOB_EIP0  = 2'd1,
        JOB_EIP1  = 2'd2
    } t_job;

    typedef enum logic [2:0] {
        RGN_NONE   = 3'd0,
        RGN_PRIO   = 3'd1,
        RGN_ENABLE = 3'd2,
        RGN_THRESH = 3'd3,
        RGN_CLAIM  = 3'd4
    } t_region;

    // Decoded bus address: region, source id, context and enable word index.
    typedef struct packed {
        t_region        rgn;
        logic [PAW-1:0] pid;
        logic [CW-1:0]  ctx;
        logic [EAW-1:0] eidx;
        logic [4:0]     word;
    } t_dec;

    t_state             r_state, n_state;
    t_job               r_job, n_job;
    t_dec               r_dec, n_dec, dec;
    logic [1:0]         r_cmd, n_cmd;
    logic [31:0]        r_wdata, n_wdata;
    logic [NSCAN-1:0]   r_levels, n_levels;
    logic [IDW-1:0]     r_id, n_id;
    logic [CLRW-1:0]    r_clr, n_clr;
    logic [NSCAN-1:0]   r_pend, n_pend;
    logic [NSCAN-1:0]   r_insvc, n_insvc;
    logic [31:0]        r_rdata, n_rdata;
    logic [1:0]         r_eip, n_eip;
    logic               r_out_valid, n_out_valid;
    logic [31:0]        r_o_rdata, n_o_rdata;
    logic [1:0]         r_o_eip, n_o_eip;

    // Address decode signals.
    logic [10:0]        id_full;
    logic [25:0]        off_en, off_ctx;
    logic [13:0]        en_ctx, cx_ctx, sel_ctx;
    logic [4:0]         en_word, word_add;
    logic [11:0]        cx_reg;
    logic [31:0]        idx_full;

    // RAM ports.
    logic                     prio_we, prio_re;
    logic [PAW-1:0]           prio_waddr, prio_raddr;
    logic [PRIORITY_BITS-1:0] prio_wdata, prio_rdata;
    logic                     en_we, en_re;
    logic [EAW-1:0]           en_waddr, en_raddr, scan_eidx;
    logic [31:0]              en_wdata, en_rdata;
    logic                     thr_we, thr_re;
    logic [CW-1:0]            thr_waddr, thr_raddr, scan_ctx;
    logic [PRIORITY_BITS-1:0] thr_wdata, thr_rdata;

    // Scan unit.
    pic_pkg::t_scan_ctl scan_ctl;
    logic [IDW-1:0]     best_id;
    logic               best_found;
    logic [NSCAN-1:0]   en_vec;
    logic [IDW-1:0]     id_next;
    logic               load_out;

    // Bits an enable word may hold: source zero and sources beyond the last are absent.
    function automatic logic [31:0] word_mask(input logic [4:0] w);
        logic [31:0] m;
        m = 32'hFFFF_FFFF;
        if (w == 5'd0) begin
            m[0] = 1'b0;
        end
        if (32'(w) == 32'(NUM_WORDS - 1)) begin
            m = m & LAST_MASK;
        end
        return m;
    endfunction

    // The address is decoded as the beat is accepted. One context number is chosen for
    // both the enable region and the context region, so a single constant multiply forms
    // the enable word index; for claim and complete it points at the context's first word.
    always_comb begin
        id_full  = i_addr[12:2];
        off_en   = i_addr - pic_pkg::ENABLE_BASE;
        off_ctx  = i_addr - pic_pkg::CONTEXT_BASE;
        en_ctx   = off_en[20:7];
        en_word  = off_en[6:2];
        cx_ctx   = off_ctx[25:12];
        cx_reg   = off_ctx[11:0];
        sel_ctx  = (i_addr < pic_pkg::CONTEXT_BASE) ? en_ctx : cx_ctx;
        word_add = (i_addr < pic_pkg::CONTEXT_BASE) ? en_word : 5'd0;
        idx_full = 32'(sel_ctx) * 32'(NUM_WORDS) + 32'(word_add);

        dec      = '0;
        dec.rgn  = RGN_NONE;
        if (i_addr[1:0] != 2'b00) begin
            dec.rgn = RGN_NONE;
        end else if (i_addr < pic_pkg::ENABLE_BASE) begin
            if ((id_full != 11'd0) && (32'(id_full) < 32'(NUM_SOURCES))) begin
                dec.rgn = RGN_PRIO;
            end
        end else if (i_addr < pic_pkg::CONTEXT_BASE) begin
            if ((32'(en_ctx) < 32'(NUM_CONTEXTS)) && (32'(en_word) < 32'(NUM_WORDS))) begin
                dec.rgn = RGN_ENABLE;
            end
        end else if (32'(cx_ctx) < 32'(NUM_CONTEXTS)) begin
            if (cx_reg == pic_pkg::THRESH_OFFSET) begin
                dec.rgn = RGN_THRESH;
            end else if (cx_reg == pic_pkg::CLAIM_OFFSET) begin
                dec.rgn = RGN_CLAIM;
            end
        end
        dec.pid  = PAW'(id_full);
        dec.ctx  = CW'(sel_ctx);
        dec.eidx = idx_full[EAW-1:0];
        dec.word = word_add;
    end

    // The context that a scan serves, and where its threshold and first enable word live.
    always_comb begin
        case (r_job)
            JOB_CLAIM: begin
                scan_ctx  = r_dec.ctx;
                scan_eidx = r_dec.eidx;
            end
            JOB_EIP0: begin
                scan_ctx  = '0;
                scan_eidx = '0;
            end
            JOB_EIP1: begin
                scan_ctx  = CW'(1);
                scan_eidx = EAW'(NUM_WORDS);
            end
            default: begin
                scan_ctx  = '0;
                scan_eidx = '0;
            end
        endcase
    end

    assign id_next = r_id + IDW'(1);

    // Priority RAM: cleared after reset, written by bus writes, read once for a bus read
    // and then once per source during every scan, one source ahead of the compare.
    assign prio_we    = ((r_state == S_CLEAR) && (32'(r_clr) < 32'(NUM_SOURCES))) ||
                        ((r_state == S_EXEC) && (r_cmd == pic_pkg::CMD_WRITE) &&
                         (r_dec.rgn == RGN_PRIO));
    assign prio_waddr = (r_state == S_CLEAR) ? PAW'(r_clr) : r_dec.pid;
    assign prio_wdata = (r_state == S_CLEAR) ? '0 : r_wdata[PRIORITY_BITS-1:0];
    assign prio_re    = (r_state == S_READ) || (r_state == S_SCAN_RD) || (r_state == S_SCAN);
    assign prio_raddr = (r_state == S_READ)    ? r_dec.pid :
                        (r_state == S_SCAN_RD) ? PAW'(1) : PAW'(id_next);

    // Enable and threshold RAMs: their read data holds for the whole of a scan.
    assign en_we     = ((r_state == S_CLEAR) && (32'(r_clr) < 32'(ENW))) ||
                       ((r_state == S_EXEC) && (r_cmd == pic_pkg::CMD_WRITE) &&
                        (r_dec.rgn == RGN_ENABLE));
    assign en_waddr  = (r_state == S_CLEAR) ? EAW'(r_clr) : r_dec.eidx;
    assign en_wdata  = (r_state == S_CLEAR) ? '0 : (r_wdata & word_mask(r_dec.word));
    assign en_re     = (r_state == S_READ) || (r_state == S_SCAN_RD);
    assign en_raddr  = (r_state == S_READ) ? r_dec.eidx : scan_eidx;

    assign thr_we    = ((r_state == S_CLEAR) && (32'(r_clr) < 32'(NUM_CONTEXTS))) ||
                       ((r_state == S_EXEC) && (r_cmd == pic_pkg::CMD_WRITE) &&
                        (r_dec.rgn == RGN_THRESH));
    assign thr_waddr = (r_state == S_CLEAR) ? CW'(r_clr) : r_dec.ctx;
    assign thr_wdata = (r_state == S_CLEAR) ? '0 : r_wdata[PRIORITY_BITS-1:0];
    assign thr_re    = en_re;
    assign thr_raddr = (r_state == S_READ) ? r_dec.ctx : scan_ctx;

    pic_ram #(
        .WIDTH (PRIORITY_BITS),
        .DEPTH (NUM_SOURCES)
    ) u_prio_ram (
        .i_clk   (i_clk),
        .i_we    (prio_we),
        .i_waddr (prio_waddr),
        .i_wdata (prio_wdata),
        .i_re    (prio_re),
        .i_raddr (prio_raddr),
        .o_rdata (prio_rdata)
    );

    pic_ram #(
        .WIDTH (32),
        .DEPTH (ENW)
    ) u_enable_ram (
        .i_clk   (i_clk),
        .i_we    (en_we),
        .i_waddr (en_waddr),
        .i_wdata (en_wdata),
        .i_re    (en_re),
        .i_raddr (en_raddr),
        .o_rdata (en_rdata)
    );

    pic_ram #(
        .WIDTH (PRIORITY_BITS),
        .DEPTH (NUM_CONTEXTS)
    ) u_thresh_ram (
        .i_clk   (i_clk),
        .i_we    (thr_we),
        .i_waddr (thr_waddr),
        .i_wdata (thr_wdata),
        .i_re    (thr_re),
        .i_raddr (thr_raddr),
        .o_rdata (thr_rdata)
    );

    // Each scan cycle offers one source to the compare unit; it is a candidate when it is
    // pending and enabled for the context being scanned.
    assign en_vec         = en_rdata[NSCAN-1:0];
    assign scan_ctl.clear = (r_state == S_SCAN_RD);
    assign scan_ctl.step  = (r_state == S_SCAN);
    assign scan_ctl.cand  = r_pend[r_id] & en_vec[r_id];

    pic_scan #(
        .PRIORITY_BITS (PRIORITY_BITS),
        .ID_W          (IDW)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (scan_ctl),
        .i_prio    (prio_rdata),
        .i_thr     (thr_rdata),
        .i_id      (r_id),
        .o_best_id (best_id),
        .o_found   (best_found)
    );

    // A finished result moves to the output register once that is free, so the next beat
    // can be taken while the previous result still waits downstream.
    assign load_out = (r_state == S_FINISH) && (!r_out_valid || !i_stall);

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_dec       = r_dec;
        n_cmd       = r_cmd;
        n_wdata     = r_wdata;
        n_levels    = r_levels;
        n_id        = r_id;
        n_clr       = r_clr;
        n_pend      = r_pend;
        n_insvc     = r_insvc;
        n_rdata     = r_rdata;
        n_eip       = r_eip;
        n_o_rdata   = r_o_rdata;
        n_o_eip     = r_o_eip;
        n_out_valid = r_out_valid && i_stall;

        case (r_state)
            S_CLEAR: begin
                n_clr = r_clr + CLRW'(1);
                if (r_clr == CLRW'(CLR_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_cmd    = i_cmd;
                    n_wdata  = i_wdata;
                    n_levels = i_irq_levels[NSCAN-1:0];
                    n_dec    = dec;
                    n_rdata  = '0;
                    n_eip    = '0;
                    n_state  = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                // Read data of the addressed word is now at the RAM outputs.
                n_job = JOB_EIP0;
                case (r_cmd)
                    pic_pkg::CMD_READ: begin
                        case (r_dec.rgn)
                            RGN_PRIO:   n_rdata = 32'(prio_rdata);
                            RGN_ENABLE: n_rdata = en_rdata;
                            RGN_THRESH: n_rdata = 32'(thr_rdata);
                            RGN_CLAIM:  n_job   = JOB_CLAIM;
                            default:    n_rdata = '0;
                        endcase
                    end
                    pic_pkg::CMD_WRITE: begin
                        // A complete only counts for an existing source enabled for the
                        // context; sources without a level line are never in service.
                        if ((r_dec.rgn == RGN_CLAIM) && (r_wdata != 32'd0) &&
                            (r_wdata < 32'(NSCAN)) && en_vec[r_wdata[IDW-1:0]]) begin
                            n_insvc[r_wdata[IDW-1:0]] = 1'b0;
                        end
                    end
                    pic_pkg::CMD_LEVELS: begin
                        n_pend = r_pend | (r_levels & LV_MASK & ~r_insvc);
                    end
                    default: begin
                        n_pend = r_pend;
                    end
                endcase
                n_state = S_SCAN_RD;
            end
            S_SCAN_RD: begin
                n_id    = IDW'(1);
                n_state = S_SCAN;
            end
            S_SCAN: begin
                n_id = id_next;
                if (r_id == IDW'(NSCAN - 1)) begin
                    n_state = S_POST;
                end
            end
            S_POST: begin
                case (r_job)
                    JOB_CLAIM: begin
                        n_rdata = 32'(best_id);
                        if (best_found) begin
                            n_pend[best_id]  = 1'b0;
                            n_insvc[best_id] = 1'b1;
                        end
                        n_job   = JOB_EIP0;
                        n_state = S_SCAN_RD;
                    end
                    JOB_EIP0: begin
                        n_eip[0] = best_found;
                        if (NUM_CONTEXTS > 1) begin
                            n_job   = JOB_EIP1;
                            n_state = S_SCAN_RD;
                        end else begin
                            n_state = S_FINISH;
                        end
                    end
                    JOB_EIP1: begin
                        n_eip[1] = best_found;
                        n_state  = S_FINISH;
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_FINISH: begin
                if (load_out) begin
                    n_o_rdata   = r_rdata;
                    n_o_eip     = r_eip;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state and the pending and in-service bits are cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_job       <= JOB_EIP0;
            r_id        <= '0;
            r_clr       <= '0;
            r_pend      <= '0;
            r_insvc     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_job       <= n_job;
            r_id        <= n_id;
            r_clr       <= n_clr;
            r_pend      <= n_pend;
            r_insvc     <= n_insvc;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dec     <= n_dec;
        r_cmd     <= n_cmd;
        r_wdata   <= n_wdata;
        r_levels  <= n_levels;
        r_rdata   <= n_rdata;
        r_eip     <= n_eip;
        r_o_rdata <= n_o_rdata;
        r_o_eip   <= n_o_eip;
    end

    assign o_stall = (r_state != S_IDLE) || !i_rst_n;
    assign o_valid = r_out_valid;
    assign o_rdata = r_o_rdata;
    assign o_eip   = r_o_eip;

endmodule

`default_nettype wire

[src/pic_checker.sv]
// Port-level assertions for the platform interrupt controller, bound to the top level.
`default_nettype none

module pic_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic [1:0]  i_cmd,
    input wire logic [25:0] i_addr,
    input wire logic [31:0] i_wdata,
    input wire logic [31:0] i_irq_levels,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [31:0] o_rdata,
    input wire logic [1:0]  o_eip
);

    // Reset leaves no result waiting.
    a_reset_no_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // The clearing pass holds off input beats straight after reset.
    a_reset_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> o_stall)
        else $error("input accepted during clearing pass");

    // One beat at a time: an accepted beat keeps the input stalled while it is worked on.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("second beat accepted while busy");

    // A stalled input beat stays offered and keeps its payload.
    a_input_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_stall) |=> (i_valid && $stable(i_cmd) && $stable(i_addr) &&
                                  $stable(i_wdata) && $stable(i_irq_levels)))
        else $error("stalled input beat changed");

    // A stalled result holds.
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_rdata) && $stable(o_eip)))
        else $error("stalled result changed");

endmodule

bind platform_interrupt_controller_top pic_checker u_pic_checker (.*);

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the platform interrupt controller: directed rows, then random.
`timescale 1ns / 1ps

module tb_top;

    // Scaled configuration of the block under test, matching its parameter defaults.
    localparam int NSRC = pic_pkg::NUM_SOURCES_DEF;
    localparam int NCTX = pic_pkg::NUM_CONTEXTS_DEF;

    // Register map, taken from the package at the width of the address bus.
    localparam logic [25:0] ENABLE_BASE   = pic_pkg::ENABLE_BASE;
    localparam logic [25:0] CONTEXT_BASE  = pic_pkg::CONTEXT_BASE;
    localparam logic [25:0] THRESH_OFFSET = 26'(pic_pkg::THRESH_OFFSET);
    localparam logic [25:0] CLAIM_OFFSET  = 26'(pic_pkg::CLAIM_OFFSET);

    // Strides of the per-context blocks in the register map.
    localparam logic [25:0] ENABLE_STRIDE  = 26'h000_0080;
    localparam logic [25:0] CONTEXT_STRIDE = 26'h000_1000;

    // The fourth command code has no meaning and must leave every register alone.
    localparam logic [1:0] CMD_NONE = 2'd3;

    // Source zero has no enable or pending bit.
    localparam logic [31:0] LIVE_SRC_BITS = 32'hFFFF_FFFE;

    // Length of the long receiver hold-off, and the wait for stray beats at the end.
    // The tail comfortably covers one more claim read.
    localparam int HOLD_CYCLES = 400;
    localparam int TAIL_CYCLES = 150;
    localparam int RAND_PER_PHASE = 250;
    localparam int MAX_GAP = 40;
    localparam int MAX_PRINTS = 50;

    // One input beat. Where typed is set, the response is given by the table itself.
    typedef struct packed {
        logic [1:0]  cmd;
        logic [25:0] addr;
        logic [31:0] wdata;
        logic [31:0] levels;
        logic        typed;
        logic [31:0] rdata;
        logic [1:0]  eip;
    } t_beat;

    typedef struct packed {
        logic [31:0] rdata;
        logic [1:0]  eip;
    } t_rsp;

    // Directed beats. The first rows walk out of reset through the extremes, where the
    // response can be read off directly; from there on the predictor decides.
    localparam t_beat DIRECTED_TAB [0:24] = '{
        // Reads straight after reset return zero and nothing is asserted.
        '{pic_pkg::CMD_READ,   26'h000_0004, 32'h0, 32'h0, 1'b1, 32'h0, 2'd0},
        '{pic_pkg::CMD_READ,   CONTEXT_BASE + CLAIM_OFFSET, 32'h0, 32'h0, 1'b1, 32'h0, 2'd0},
        // Every line high: all sources pend, but none has a priority yet.
        '{pic_pkg::CMD_LEVELS, 26'h000_0000, 32'h0, 32'hFFFF_FFFF, 1'b1, 32'h0, 2'd0},
        // Source zero ignores a priority write.
        '{pic_pkg::CMD_WRITE,  26'h000_0000, 32'hFFFF_FFFF, 32'h0, 1'b1, 32'h0, 2'd0},
        // Highest source, priority written as all ones: its low bits give the top value.
        '{pic_pkg::CMD_WRITE,  26'h000_007C, 32'hFFFF_FFFF, 32'h0, 1'b1, 32'h0, 2'd0},
        '{pic_pkg::CMD_READ,   26'h000_007C, 32'h0, 32'h0, 1'b1, 32'h7, 2'd0},
        // Enabling everything for context 0 raises its request; bit zero stays clear.
        '{pic_pkg::CMD_WRITE,  ENABLE_BASE, 32'hFFFF_FFFF, 32'h0, 1'b1, 32'h0, 2'd1},
        '{pic_pkg::CMD_READ,   ENABLE_BASE, 32'h0, 32'h0, 1'b1, 32'hFFFF_FFFE, 2'd1},
        '{pic_pkg::CMD_WRITE,  ENABLE_BASE + ENABLE_STRIDE, 32'h8000_0001, 32'h0,
          1'b1, 32'h0, 2'd3},
        // Equal top priority on source 5 and source 31: the lower id wins the claim.
        '{pic_pkg::CMD_WRITE,  26'h000_0014, 32'h7, 32'h0, 1'b0, 32'h0, 2'd0},
        '{pic_pkg::CMD_WRITE,  26'h000_0008, 32'h3, 32'h0, 1'b0, 32'h0, 2'd0},
        '{pic_pkg::CMD_READ,   CONTEXT_BASE + CLAIM_OFFSET, 32'h0, 32'h0, 1'b0, 32'h0, 2'd0},
        '{pic_pkg::CMD_READ,   CONTEXT_BASE + CLAIM_OFFSET, 32'h0, 32'h0, 1'b0, 32'h0, 2'd0},
        // Maximum threshold on context 1 masks everything there.
        '{pic_pkg::CMD_WRITE,  CONTEXT_BASE + CONTEXT_STRIDE, 32'hFFFF_FFFF, 32'h0,
          1'b0, 32'h0, 2'd0},
        '{pic_pkg::CMD_READ,   CONTEXT_BASE + CONTEXT_STRIDE, 32'h0, 32'h0, 1'b0, 32'h0, 2'd0},
        // Completions with id zero, an id out of range and an id not enabled are ignored.
        '{pic_pkg::CMD_WRITE,  CONTEXT_BASE + CLAIM_OFFSET, 32'h0, 32'h0, 1'b0, 32'h0, 2'd0},
        '{pic_pkg::CMD_WRITE,  CONTEXT_BASE + CLAIM_OFFSET, 32'd32, 32'h0, 1'b0, 32'h0, 2'd0},
        '{pic_pkg::CMD_WRITE,  CONTEXT_BASE + CONTEXT_STRIDE + CLAIM_OFFSET, 32'd5, 32'h0,
          1'b0, 32'h0, 2'd0},
        '{pic_pkg::CMD_WRITE,  CONTEXT_BASE + CLAIM_OFFSET, 32'd5, 32'h0, 1'b0, 32'h0, 2'd0},
        // Source 5 may pend again now that it is complete; low lines clear nothing.
        '{pic_pkg::CMD_LEVELS, 26'h000_0000, 32'h0, 32'h0000_0021, 1'b0, 32'h0, 2'd0},
        // A context beyond the last, for enables and for claims, and an unaligned read.
        '{pic_pkg::CMD_READ,   ENABLE_BASE + 26'd2 * ENABLE_STRIDE, 32'h0, 32'h0,
          1'b0, 32'h0, 2'd0},
        '{pic_pkg::CMD_READ,   CONTEXT_BASE + 26'd2 * CONTEXT_STRIDE + CLAIM_OFFSET,
          32'h0, 32'h0, 1'b0, 32'h0, 2'd0},
        '{pic_pkg::CMD_READ,   ENABLE_BASE + 26'h2, 32'h0, 32'h0, 1'b0, 32'h0, 2'd0},
        // The unused command and a write to the top of the address space do nothing.
        '{CMD_NONE,            26'h3FF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 2'd0},
        '{pic_pkg::CMD_WRITE,  26'h3FF_FFFC, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0, 2'd0}
    };

    // Signals to and from the block. Every input is known from time zero.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_cmd = pic_pkg::CMD_READ;
    logic [25:0] i_addr = '0;
    logic [31:0] i_wdata = '0;
    logic [31:0] i_irq_levels = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_rdata;
    logic [1:0]  o_eip;

    // Predicted state of the controller.
    logic [2:0]  src_prio [NSRC];
    logic [31:0] ctx_enable [NCTX];
    logic [2:0]  ctx_thresh [NCTX];
    logic [31:0] pend_bits;
    logic [31:0] serv_bits;

    // Responses owed by the block, oldest first.
    t_rsp bus_rsp_q [$];

    int err_count = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // The hold-off is requested by bumping hold_req; the receiver process owns the count.
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;

    platform_interrupt_controller_top i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_cmd        (i_cmd),
        .i_addr       (i_addr),
        .i_wdata      (i_wdata),
        .i_irq_levels (i_irq_levels),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_rdata      (o_rdata),
        .o_eip        (o_eip)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Safety net: far beyond the slowest legal run.
    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Best claimable source of a context: highest priority above the threshold, the
    // lowest id on a tie, or zero when nothing qualifies.
    function automatic logic [4:0] best_source_of(input int ctx);
        logic [4:0] best;
        logic [2:0] best_p;
        best = '0;
        best_p = '0;
        for (int id = 1; id < NSRC; id++) begin
            if (pend_bits[id] && ctx_enable[ctx][id] && src_prio[id] > ctx_thresh[ctx]) begin
                if (best == '0 || src_prio[id] > best_p) begin
                    best = 5'(id);
                    best_p = src_prio[id];
                end
            end
        end
        return best;
    endfunction

    // Applies one accepted beat to the predicted state and works out its response.
    function automatic void predict_response(input t_beat b, output logic [31:0] rd,
                                             output logic [1:0] ep);
        logic [25:0] off;
        logic        wr;
        int          ctx;
        int          word;
        int          id;
        logic [4:0]  win;
        rd = '0;
        ep = '0;
        wr = (b.cmd == pic_pkg::CMD_WRITE);
        case (b.cmd)
            pic_pkg::CMD_READ, pic_pkg::CMD_WRITE: begin
                if (b.addr[1:0] != 2'b00) begin
                    // Unaligned: nothing happens.
                end else if (b.addr < ENABLE_BASE) begin
                    id = int'(b.addr >> 2);
                    if (id != 0 && id < NSRC) begin
                        if (wr) src_prio[id] = b.wdata[2:0];
                        else rd = 32'(src_prio[id]);
                    end
                end else if (b.addr < CONTEXT_BASE) begin
                    off = b.addr - ENABLE_BASE;
                    ctx = int'(off / ENABLE_STRIDE);
                    word = int'((off % ENABLE_STRIDE) >> 2);
                    if (ctx < NCTX && word == 0) begin
                        if (wr) ctx_enable[ctx] = b.wdata & LIVE_SRC_BITS;
                        else rd = ctx_enable[ctx];
                    end
                end else begin
                    off = b.addr - CONTEXT_BASE;
                    ctx = int'(off / CONTEXT_STRIDE);
                    if (ctx < NCTX) begin
                        if (off % CONTEXT_STRIDE == THRESH_OFFSET) begin
                            if (wr) ctx_thresh[ctx] = b.wdata[2:0];
                            else rd = 32'(ctx_thresh[ctx]);
                        end else if (off % CONTEXT_STRIDE == CLAIM_OFFSET) begin
                            if (wr) begin
                                if (b.wdata >= 32'd1 && b.wdata < 32'(NSRC) &&
                                    ctx_enable[ctx][b.wdata[4:0]])
                                    serv_bits[b.wdata[4:0]] = 1'b0;
                            end else begin
                                win = best_source_of(ctx);
                                if (win != '0) begin
                                    pend_bits[win] = 1'b0;
                                    serv_bits[win] = 1'b1;
                                end
                                rd = 32'(win);
                            end
                        end
                    end
                end
            end
            pic_pkg::CMD_LEVELS: pend_bits = pend_bits | (b.levels & LIVE_SRC_BITS & ~serv_bits);
            default: ;
        endcase
        for (int c = 0; c < NCTX && c < 2; c++)
            if (best_source_of(c) != '0) ep[c] = 1'b1;
    endfunction

    // Random beat. Most of the traffic is the usual driver cycle of levels, claims and
    // completions on live in-service ids, with register writes mixed in to move the
    // priorities, enables and thresholds around; a small share is pure noise.
    function automatic t_beat random_beat();
        t_beat b;
        int    pick;
        int    ctx;
        int    id;
        b = '0;
        b.wdata = $urandom();
        b.levels = $urandom();
        b.cmd = pic_pkg::CMD_WRITE;
        ctx = $urandom_range(0, NCTX - 1);
        pick = $urandom_range(0, 99);
        if (pick < 20) begin
            b.cmd = pic_pkg::CMD_LEVELS;
            if ($urandom_range(0, 1) == 0) b.levels = $urandom() & $urandom() & $urandom();
        end else if (pick < 45) begin
            b.cmd = pic_pkg::CMD_READ;
            b.addr = CONTEXT_BASE + 26'(ctx) * CONTEXT_STRIDE + CLAIM_OFFSET;
        end else if (pick < 65) begin
            // Complete a source that is in service, most of the time.
            id = $urandom_range(0, 40);
            if (serv_bits != '0 && $urandom_range(0, 9) < 8) begin
                id = $urandom_range(1, NSRC - 1);
                while (!serv_bits[id]) id = (id % (NSRC - 1)) + 1;
            end
            b.wdata = 32'(id);
            b.addr = CONTEXT_BASE + 26'(ctx) * CONTEXT_STRIDE + CLAIM_OFFSET;
        end else if (pick < 75) begin
            b.addr = 26'($urandom_range(0, NSRC + 3)) << 2;
        end else if (pick < 83) begin
            if ($urandom_range(0, 9) == 0) ctx = NCTX;
            b.addr = ENABLE_BASE + 26'(ctx) * ENABLE_STRIDE;
        end else if (pick < 90) begin
            // Keep thresholds low often enough for claims to succeed.
            if ($urandom_range(0, 1) == 0) b.wdata[2:0] = 3'($urandom_range(0, 2));
            b.addr = CONTEXT_BASE + 26'(ctx) * CONTEXT_STRIDE + THRESH_OFFSET;
        end else if (pick < 95) begin
            b.cmd = pic_pkg::CMD_READ;
            case ($urandom_range(0, 2))
                0: b.addr = 26'($urandom_range(0, NSRC - 1)) << 2;
                1: b.addr = ENABLE_BASE + 26'(ctx) * ENABLE_STRIDE;
                default: b.addr = CONTEXT_BASE + 26'(ctx) * CONTEXT_STRIDE;
            endcase
        end else begin
            b.cmd = 2'($urandom_range(0, 3));
            b.addr = 26'($urandom());
        end
        return b;
    endfunction

    task automatic report_mismatch(input string what);
        err_count++;
        if (err_count <= MAX_PRINTS) $display("ERROR at %0t ns: %s", $time, what);
    endtask

    // Offers one beat after a random gap and returns at the edge where it is taken.
    task automatic send_beat(input t_beat b);
        int          gap;
        logic [31:0] rd;
        logic [1:0]  ep;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_cmd <= b.cmd;
        i_addr <= b.addr;
        i_wdata <= b.wdata;
        i_irq_levels <= b.levels;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        predict_response(b, rd, ep);
        if (b.typed) begin
            rd = b.rdata;
            ep = b.eip;
        end
        bus_rsp_q.push_back('{rdata: rd, eip: ep});
    endtask

    // The sender stops offering until every owed response has come back.
    task automatic drain_responses();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (bus_rsp_q.size() != 0);
    endtask

    // Receiver: random stall as the phase dictates, or a long hold-off on request.
    always @(posedge i_clk) begin
        if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            i_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Response checker. Values are sampled before this edge's updates land.
    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (bus_rsp_q.size() == 0) begin
                report_mismatch($sformatf("response beat with none owed, rdata %h eip %b",
                                          o_rdata, o_eip));
            end else begin
                want = bus_rsp_q.pop_front();
                if (o_rdata !== want.rdata)
                    report_mismatch($sformatf("rdata %h, predicted %h", o_rdata, want.rdata));
                if (o_eip !== want.eip)
                    report_mismatch($sformatf("eip %b, predicted %b", o_eip, want.eip));
            end
        end
    end

    // Main sequence: reset, the directed table, four random phases, then the tail.
    initial begin
        foreach (src_prio[i]) src_prio[i] = '0;
        foreach (ctx_enable[i]) ctx_enable[i] = '0;
        foreach (ctx_thresh[i]) ctx_thresh[i] = '0;
        pend_bits = '0;
        serv_bits = '0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The directed rows run without gaps; the block itself stalls through its
        // clearing pass after reset, which the handshake absorbs.
        foreach (DIRECTED_TAB[r]) send_beat(DIRECTED_TAB[r]);
        drain_responses();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            for (int n = 0; n < RAND_PER_PHASE; n++) begin
                // In two phases the receiver holds off for a long stretch while beats
                // keep being offered, so the block backs up and stalls its input.
                if (n == RAND_PER_PHASE / 2 && (phase == 0 || phase == 3))
                    hold_req = hold_req + 1;
                send_beat(random_beat());
            end
            drain_responses();
        end

        // Nothing owed now; give any stray beat time to show itself.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
src/pic_pkg.sv
src/pic_ram.sv
src/pic_scan.sv
src/platform_interrupt_controller_top.sv
src/pic_checker.sv
tb/tb_top.sv
